// ----- rtl/core/dsv_pkg.sv -----
// Shared types, constants and controller codes for the decaying sample voice.
// Used by dsv_datapath, dsv_ctrl and decaying_sample_voice_core.
`default_nettype none

package dsv_pkg;

    // Sample table geometry
    localparam int SAMPLE_DEPTH = 8192;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
    // Index part of the position must reach SAMPLE_DEPTH + 1 after the last step
    localparam int IDX_W        = $clog2(SAMPLE_DEPTH + 2);
    localparam int FRAC_W       = 16;
    localparam int POS_W        = IDX_W + FRAC_W;

    // Fixed-point formats
    localparam int VOL_W   = 25;   // Q1.24
    localparam int PITCH_W = 18;   // Q2.16

    localparam logic [VOL_W-1:0]   ONE_Q24     = 25'd16777216;
    localparam logic [VOL_W-1:0]   DECAY_RESET = 25'd16609443;
    localparam logic [PITCH_W-1:0] PITCH_RESET = 18'd65536;
    localparam logic [PITCH_W-1:0] PITCH_BASE  = 18'd32768;
    localparam logic [PITCH_W-1:0] PITCH_MAX   = 18'd131072;
    localparam logic [15:0]        IDLE_WORD   = 16'd32767;

    // Knob scaling: pitch = 32768 + round(raw * 98304 / 4095)
    localparam int KNOB_FULL   = 4095;
    localparam int PITCH_SPAN  = 98304;
    localparam int PITCH_ROUND = 2047;
    localparam int PN_W        = 29;   // pitch numerator width
    localparam int PQ_W        = 17;   // pitch quotient width
    localparam int PR_W        = 13;   // pitch remainder width (< 2 * 4095)
    localparam int PITCH_SHIFT = 29;
    localparam logic [17:0] PITCH_RECIP = 18'((64'd1 << PITCH_SHIFT) / 64'd4095);

    // Knob scaling: decay = 1.0 - round((4095 - raw) * 2^25 / 4095000)
    localparam int DECAY_NUM_SHIFT = 25;
    localparam int DECAY_ROUND     = 2047500;
    localparam int DECAY_DIV       = 4095000;
    localparam int DN_W            = 37;   // decay numerator width
    localparam int DQ_W            = 16;   // decay quotient width
    localparam int DR_W            = 23;   // decay remainder width (< 2 * 4095000)
    localparam int DECAY_SHIFT     = 38;
    localparam logic [16:0] DECAY_RECIP = 17'((64'd1 << DECAY_SHIFT) / 64'd4095000);
    localparam logic [VOL_W-1:0] DECAY_MIN =
        25'(64'd16777216 - (64'd4095 * 64'd33554432 + 64'd2047500) / 64'd4095000);

    // Item action codes
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_GATE  = 2'd1,
        ACT_KNOB  = 2'd2,
        ACT_WRITE = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]  action;
        logic        gate_level;
        logic [11:0] raw_pitch;
        logic [11:0] raw_decay;
        logic [12:0] write_address;
        logic [7:0]  write_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pwm_word;
        logic        is_playing;
    } t_out_item;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_IDX,
        S_TICK_RD0,
        S_TICK_RD1,
        S_TICK_MUL,
        S_TICK_SCALE,
        S_TICK_EMIT,
        S_IDLE_EMIT,
        S_KNOB_EST,
        S_KNOB_REM,
        S_KNOB_FIX
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic gate_we;
        logic mem_we;
        logic knob_load;
        logic knob_est;
        logic knob_rem;
        logic knob_fix;
        logic rd_first;
        logic rd_second;
        logic cap_s0;
        logic cap_diff;
        logic do_interp;
        logic do_scale;
        logic stop;
        logic emit_play;
        logic emit_idle;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic playing;
        logic at_end;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- rtl/core/dsv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`default_nettype none

module dsv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/dsv_datapath.sv -----
// Datapath of the decaying sample voice: voice state, sample memory,
// interpolation, volume scaling, knob scaling and the output register.
// Depends on dsv_pkg and dsv_ram.
`default_nettype none

module dsv_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dsv_pkg::t_in_item   i_in_item,
    input  wire dsv_pkg::t_dp_cmd    i_cmd,
    output dsv_pkg::t_dp_status      o_status,
    output logic                     o_out_valid,
    output dsv_pkg::t_out_item       o_out_item,
    input  wire logic                i_out_stall
);

    import dsv_pkg::*;

    // Map an unsigned byte (128 = zero) to a signed 16-bit sample
    function automatic logic signed [15:0] centered(input logic [7:0] b);
        centered = $signed({~b[7], b[6:0], 8'h00});
    endfunction

    // Voice state
    logic                  r_active,    n_active;
    logic                  r_last_gate, n_last_gate;
    logic [POS_W-1:0]      r_pos,       n_pos;
    logic [VOL_W-1:0]      r_vol,       n_vol;
    logic [PITCH_W-1:0]    r_pitch,     n_pitch;
    logic [VOL_W-1:0]      r_decay,     n_decay;
    logic                  r_out_valid, n_out_valid;

    // Tick pipeline registers
    logic signed [15:0]    r_s0;
    logic signed [16:0]    r_diff;
    logic signed [31:0]    r_acc;
    logic signed [57:0]    r_prod;
    logic [VOL_W-1:0]      r_vol_next;
    t_out_item             r_out;

    // Knob division registers
    logic [PN_W-1:0]       r_np;
    logic [DN_W-1:0]       r_nd;
    logic [PQ_W-1:0]       r_qp;
    logic [DQ_W-1:0]       r_qd;
    logic [PR_W-1:0]       r_rp;
    logic [DR_W-1:0]       r_rd;

    logic [IDX_W-1:0]      w_idx;
    logic [FRAC_W-1:0]     w_frac;
    logic                  w_is_last;
    logic                  w_wr_ok;
    logic [ADDR_W-1:0]     w_raddr;
    logic [7:0]            w_rdata;
    logic signed [15:0]    w_s1;
    logic signed [16:0]    w_diff;
    logic signed [33:0]    w_base;
    logic signed [33:0]    w_interp;
    logic signed [33:0]    w_acc_sum;
    logic [49:0]           w_vol_mul;
    logic signed [57:0]    w_prod;
    logic signed [57:0]    w_bias;
    logic signed [57:0]    w_round;
    logic signed [17:0]    w_val;
    logic signed [15:0]    w_sat;
    logic [46:0]           w_p_est;
    logic [53:0]           w_d_est;
    logic [PN_W-1:0]       w_p_rem;
    logic [DN_W-1:0]       w_d_rem;
    logic                  w_out_take;
    logic                  w_out_free;

    // Position split and sample memory access
    assign w_idx     = r_pos[POS_W-1:FRAC_W];
    assign w_frac    = r_pos[FRAC_W-1:0];
    assign w_is_last = (w_idx == IDX_W'(SAMPLE_DEPTH - 1));
    assign w_wr_ok   = (32'(i_in_item.write_address) < 32'(SAMPLE_DEPTH));
    assign w_raddr   = i_cmd.rd_first ? ADDR_W'(w_idx) : ADDR_W'(w_idx + IDX_W'(1));

    dsv_ram #(
        .WIDTH (8),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we && w_wr_ok),
        .i_waddr (ADDR_W'(i_in_item.write_address)),
        .i_wdata (i_in_item.write_byte),
        .i_re    (i_cmd.rd_first || i_cmd.rd_second),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Interpolation: acc = s0 * 2^16 + frac * (s1 - s0); byte past the end is zero
    assign w_s1      = w_is_last ? 16'sh0000 : centered(w_rdata);
    assign w_diff    = $signed({w_s1[15], w_s1}) - $signed({r_s0[15], r_s0});
    assign w_base    = $signed({{2{r_s0[15]}}, r_s0, 16'h0000});
    assign w_interp  = $signed({1'b0, w_frac}) * r_diff;
    assign w_acc_sum = w_base + w_interp;

    // Volume decay for the next tick
    assign w_vol_mul = 50'(r_vol) * 50'(r_decay);

    // Volume scaling, truncation toward zero and saturation
    assign w_prod  = r_acc * $signed({1'b0, r_vol});
    assign w_bias  = r_prod[57] ? $signed({18'h0, {40{1'b1}}}) : 58'sd0;
    assign w_round = r_prod + w_bias;
    assign w_val   = w_round[57:40];

    always_comb begin
        if (w_val > 18'sd32767) begin
            w_sat = 16'sh7fff;
        end else if (w_val < -18'sd32768) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_val[15:0];
        end
    end

    // Knob division by reciprocal: estimate, remainder, one-step correction
    assign w_p_est = 47'(r_np) * 47'(PITCH_RECIP);
    assign w_d_est = 54'(r_nd) * 54'(DECAY_RECIP);
    assign w_p_rem = r_np - PN_W'(PN_W'(r_qp) * PN_W'(KNOB_FULL));
    assign w_d_rem = r_nd - DN_W'(DN_W'(r_qd) * DN_W'(DECAY_DIV));

    // Output register handshake
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state of the voice
    always_comb begin
        n_active    = r_active;
        n_last_gate = r_last_gate;
        n_pos       = r_pos;
        n_vol       = r_vol;
        n_pitch     = r_pitch;
        n_decay     = r_decay;
        n_out_valid = r_out_valid;

        if (i_cmd.gate_we) begin
            n_last_gate = i_in_item.gate_level;
            if (i_in_item.gate_level && !r_last_gate) begin
                n_active = 1'b1;
                n_pos    = '0;
                n_vol    = ONE_Q24;
            end
        end
        if (i_cmd.stop) begin
            n_active = 1'b0;
        end
        if (i_cmd.emit_play) begin
            n_pos = r_pos + POS_W'(r_pitch);
            n_vol = r_vol_next;
        end
        if (i_cmd.knob_fix) begin
            n_pitch = PITCH_BASE + PITCH_W'(r_qp)
                      + PITCH_W'(r_rp >= PR_W'(KNOB_FULL));
            n_decay = ONE_Q24 - (VOL_W'(r_qd) + VOL_W'(r_rd >= DR_W'(DECAY_DIV)));
        end
        if (i_cmd.emit_play || i_cmd.emit_idle) begin
            n_out_valid = 1'b1;
        end else if (w_out_take) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and voice state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_last_gate <= 1'b0;
            r_pos       <= '0;
            r_vol       <= '0;
            r_pitch     <= PITCH_RESET;
            r_decay     <= DECAY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_last_gate <= n_last_gate;
            r_pos       <= n_pos;
            r_vol       <= n_vol;
            r_pitch     <= n_pitch;
            r_decay     <= n_decay;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_s0) begin
            r_s0 <= centered(w_rdata);
        end
        if (i_cmd.cap_diff) begin
            r_diff <= w_diff;
        end
        if (i_cmd.do_interp) begin
            r_acc      <= w_acc_sum[31:0];
            r_vol_next <= w_vol_mul[48:24];
        end
        if (i_cmd.do_scale) begin
            r_prod <= w_prod;
        end
        if (i_cmd.knob_load) begin
            r_np <= PN_W'(i_in_item.raw_pitch) * PN_W'(PITCH_SPAN) + PN_W'(PITCH_ROUND);
            r_nd <= (DN_W'(12'(KNOB_FULL) - i_in_item.raw_decay) << DECAY_NUM_SHIFT)
                    + DN_W'(DECAY_ROUND);
        end
        if (i_cmd.knob_est) begin
            r_qp <= PQ_W'(w_p_est >> PITCH_SHIFT);
            r_qd <= DQ_W'(w_d_est >> DECAY_SHIFT);
        end
        if (i_cmd.knob_rem) begin
            r_rp <= w_p_rem[PR_W-1:0];
            r_rd <= w_d_rem[DR_W-1:0];
        end
        if (i_cmd.emit_play) begin
            r_out.pwm_word   <= {~w_sat[15], w_sat[14:0]};
            r_out.is_playing <= 1'b1;
        end else if (i_cmd.emit_idle) begin
            r_out.pwm_word   <= IDLE_WORD;
            r_out.is_playing <= 1'b0;
        end
    end

    assign o_status.playing  = r_active;
    assign o_status.at_end   = (w_idx >= IDX_W'(SAMPLE_DEPTH));
    assign o_status.out_free = w_out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;

    // Position stays within one pitch step past the table end while playing
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (w_idx <= IDX_W'(SAMPLE_DEPTH + 1)))
        else $error("play position ran past the end bound");

    // Decay never raises the volume above unity
    a_vol_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vol <= ONE_Q24)
        else $error("volume above 1.0");

    // Knob scaling keeps pitch within 0.5 to 2.0
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pitch >= PITCH_BASE) && (r_pitch <= PITCH_MAX))
        else $error("pitch step out of range");

    // Decay is the reset value or within the knob range
    a_decay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_decay >= DECAY_MIN) || (r_decay == DECAY_RESET)) && (r_decay <= ONE_Q24))
        else $error("decay factor out of range");

endmodule

`default_nettype wire

// ----- rtl/core/dsv_ctrl.sv -----
// Controller state machine of the decaying sample voice: accepts items and
// sequences the datapath through ticks and knob updates. Depends on dsv_pkg.
`default_nettype none

module dsv_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic [1:0]          i_action,
    output logic                     o_in_stall,
    output dsv_pkg::t_dp_cmd         o_cmd,
    input  wire dsv_pkg::t_dp_status i_status
);

    import dsv_pkg::*;

    t_state r_state, n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && !o_in_stall;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_action'(i_action))
                        ACT_TICK: begin
                            n_state = S_TICK_IDX;
                        end
                        ACT_GATE: begin
                            o_cmd.gate_we = 1'b1;
                        end
                        ACT_KNOB: begin
                            o_cmd.knob_load = 1'b1;
                            n_state         = S_KNOB_EST;
                        end
                        ACT_WRITE: begin
                            o_cmd.mem_we = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Idle voice or end of table gives the idle word
            S_TICK_IDX: begin
                if (!i_status.playing) begin
                    n_state = S_IDLE_EMIT;
                end else if (i_status.at_end) begin
                    o_cmd.stop = 1'b1;
                    n_state    = S_IDLE_EMIT;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_TICK_RD0;
                end
            end
            S_TICK_RD0: begin
                o_cmd.rd_second = 1'b1;
                o_cmd.cap_s0    = 1'b1;
                n_state         = S_TICK_RD1;
            end
            S_TICK_RD1: begin
                o_cmd.cap_diff = 1'b1;
                n_state        = S_TICK_MUL;
            end
            S_TICK_MUL: begin
                o_cmd.do_interp = 1'b1;
                n_state         = S_TICK_SCALE;
            end
            S_TICK_SCALE: begin
                o_cmd.do_scale = 1'b1;
                n_state        = S_TICK_EMIT;
            end
            // Wait for the output register before committing the tick
            S_TICK_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_play = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_IDLE_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_idle = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_KNOB_EST: begin
                o_cmd.knob_est = 1'b1;
                n_state        = S_KNOB_REM;
            end
            S_KNOB_REM: begin
                o_cmd.knob_rem = 1'b1;
                n_state        = S_KNOB_FIX;
            end
            S_KNOB_FIX: begin
                o_cmd.knob_fix = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The sequencer only leaves idle on an accepted transaction
    a_start_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_IDLE) && ($past(r_state) == S_IDLE)) |-> $past(w_accept))
        else $error("sequence started without an accepted transaction");

endmodule

`default_nettype wire

// ----- rtl/core/decaying_sample_voice_core.sv -----
// One-shot drum voice that plays an 8-bit sample table with linear
// interpolation and exponential volume decay. A rising gate restarts playback
// at the table start with full volume; every tick item returns one PWM word
// (32767 when idle), while gate, knob and sample-write items return nothing.
// Items are taken one at a time: gate and sample-write transactions complete
// in the idle state and a knob transaction steps through estimate, remainder
// and fix states. A playing tick makes two successive reads of the single
// read port of the sample memory, then interpolates, scales and saturates;
// an idle or end-of-table tick goes straight to the idle word. Every tick
// waits for the previous result to be taken. The sample memory is
// not cleared at reset; load every entry that playback can reach first.
// Depends on dsv_pkg, dsv_ctrl, dsv_datapath and dsv_ram.
`default_nettype none

module decaying_sample_voice_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire dsv_pkg::t_in_item i_in_item,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output dsv_pkg::t_out_item     o_out_item,
    input  wire logic              i_out_stall
);

    import dsv_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer
    dsv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_item.action),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    // Voice state, arithmetic and output register
    dsv_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
